// ===== hdl/assert_macros.svh =====
// assertion macros used by the allocator top file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property with reset masking
`define FFHA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked property that also holds during reset
`define FFHA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// shared types and constants of the first-fit heap allocator
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

    localparam int PAGE_BYTES_DEF  = 4096;
    localparam int HEAP_BYTES_DEF  = 65536;
    localparam int MAX_REGIONS_DEF = 16;
    localparam int MIN_PAYLOAD_DEF = 16;

    localparam int HDR_BYTES = 8;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_NO_ROOM = 2'd1;
    localparam logic [1:0] STAT_FOREIGN = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_START,
        S_A_CHK,
        S_A_WR2,
        S_C_INIT,
        S_C_SIZE,
        S_F_FIND,
        S_F_CHK,
        S_M_RD,
        S_M_CUR,
        S_M_NXT,
        S_FIN
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/ffha_req_if.sv =====
// ----------------------------------------------------------------------------
// ffha_req_if
// request channel: allocate or free
// ----------------------------------------------------------------------------
`default_nettype none

interface ffha_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [15:0] request_bytes;
    logic [31:0] release_address;

    modport source (output valid, opcode, request_bytes, release_address, input ready);
    modport sink (input valid, opcode, request_bytes, release_address, output ready);
endinterface

`default_nettype wire

// ===== hdl/ffha_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ffha_rsp_if
// result channel: granted address and status
// ----------------------------------------------------------------------------
`default_nettype none

interface ffha_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_address;
    logic [1:0]  status;

    modport source (output valid, result_address, status, input ready);
    modport sink (input valid, result_address, status, output ready);
endinterface

`default_nettype wire

// ===== hdl/ffha_ram.sv =====
// ----------------------------------------------------------------------------
// ffha_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 16384
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

`default_nettype wire

// ===== hdl/ffha_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffha_ctrl
// request sequencer: region walk, split, carve, free and merge
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_ctrl #(
    parameter int PAGE_BYTES  = ffha_pkg::PAGE_BYTES_DEF,
    parameter int HEAP_BYTES  = ffha_pkg::HEAP_BYTES_DEF,
    parameter int MAX_REGIONS = ffha_pkg::MAX_REGIONS_DEF,
    parameter int MIN_PAYLOAD = ffha_pkg::MIN_PAYLOAD_DEF,
    localparam int SZ_W = $clog2(HEAP_BYTES),
    localparam int HW   = SZ_W + 1,
    localparam int HA_W = $clog2(HEAP_BYTES / 4),
    localparam int OFF_W = SZ_W + 1,
    localparam int RC_W = $clog2(MAX_REGIONS + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    ffha_req_if.sink              req,
    ffha_rsp_if.source            rsp,
    input  wire logic [31:0]      heap_base,
    output logic      [HA_W-1:0]  rd_addr,
    input  wire logic [HW-1:0]    rd_data,
    output logic                  wr_en,
    output logic      [HA_W-1:0]  wr_addr,
    output logic      [HW-1:0]    wr_data,
    output logic                  busy,
    output logic      [RC_W-1:0]  region_count,
    output logic      [OFF_W-1:0] carve_offset
);
    import ffha_pkg::*;

    localparam int CW   = ((SZ_W > 17) ? SZ_W : 17) + 3;
    localparam int RI_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam logic [CW-1:0] HDR_C   = CW'(HDR_BYTES);
    localparam logic [CW-1:0] SPLIT_C = CW'(HDR_BYTES + MIN_PAYLOAD);
    localparam logic [CW-1:0] PAGE_C  = CW'(PAGE_BYTES);
    localparam logic [CW-1:0] HEAP_C  = CW'(HEAP_BYTES);
    localparam logic [RC_W-1:0] MAXR_C = RC_W'(MAX_REGIONS);

    state_t state_reg, state_next;
    logic [CW-1:0]    need_reg, need_next;
    logic [CW-1:0]    off_reg, off_next;
    logic [RC_W-1:0]  r_reg, r_next;
    logic [CW-1:0]    pos_reg, pos_next;
    logic [CW-1:0]    end_reg, end_next;
    logic [CW-1:0]    nxt_reg, nxt_next;
    logic [CW-1:0]    bytes_reg, bytes_next;
    logic [HW-1:0]    hc_reg, hc_next;
    logic             carved_reg, carved_next;
    logic [RC_W-1:0]  count_reg, count_next;
    logic [OFF_W-1:0] carve_reg, carve_next;
    logic [31:0]      fin_addr_reg, fin_addr_next;
    logic [1:0]       fin_stat_reg, fin_stat_next;
    logic             out_valid_reg;
    logic [31:0]      out_addr_reg;
    logic [1:0]       out_stat_reg;
    logic [OFF_W-1:0] reg_start [MAX_REGIONS];
    logic [OFF_W-1:0] reg_len   [MAX_REGIONS];
    logic             reg_we;

    logic [RI_W-1:0]  ri;
    logic [CW-1:0]    rs, re, h_size, pos_step, hc_size, merged, rem, off_full, split_pos;
    logic             h_free, load_out;
    logic [31:0]      off32;

    assign ri        = r_reg[RI_W-1:0];
    assign rs        = CW'(reg_start[ri]);
    assign re        = CW'(reg_start[ri]) + CW'(reg_len[ri]);
    assign h_size    = CW'(rd_data[SZ_W-1:0]);
    assign h_free    = rd_data[SZ_W];
    assign pos_step  = pos_reg + HDR_C + h_size;
    assign hc_size   = CW'(hc_reg[SZ_W-1:0]);
    assign merged    = hc_size + HDR_C + h_size;
    assign rem       = h_size - need_reg;
    assign split_pos = pos_reg + HDR_C + need_reg;
    assign off32     = req.release_address - heap_base;
    assign off_full  = CW'(off32[SZ_W-1:0]);

    assign req.ready = (state_reg == S_IDLE);
    assign busy = (state_reg != S_IDLE);
    assign region_count = count_reg;
    assign carve_offset = carve_reg;
    assign load_out = (state_reg == S_FIN) && (!out_valid_reg || rsp.ready);

    assign rsp.valid = out_valid_reg;
    assign rsp.result_address = out_addr_reg;
    assign rsp.status = out_stat_reg;

    always_comb
    begin
        state_next    = state_reg;
        need_next     = need_reg;
        off_next      = off_reg;
        r_next        = r_reg;
        pos_next      = pos_reg;
        end_next      = end_reg;
        nxt_next      = nxt_reg;
        bytes_next    = bytes_reg;
        hc_next       = hc_reg;
        carved_next   = carved_reg;
        count_next    = count_reg;
        carve_next    = carve_reg;
        fin_addr_next = fin_addr_reg;
        fin_stat_next = fin_stat_reg;
        reg_we        = 1'b0;
        rd_addr       = pos_reg[HA_W+1:2];
        wr_en         = 1'b0;
        wr_addr       = pos_reg[HA_W+1:2];
        wr_data       = rd_data;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    r_next        = '0;
                    carved_next   = 1'b0;
                    fin_addr_next = '0;
                    need_next     = CW'(({1'b0, req.request_bytes} + 17'd3) & ~17'd3);
                    off_next      = off_full;
                    if (req.opcode == OP_FREE)
                    begin
                        if (off32 >= 32'(HEAP_BYTES))
                        begin
                            fin_stat_next = STAT_FOREIGN;
                            state_next    = S_FIN;
                        end
                        else
                        begin
                            state_next = S_F_FIND;
                        end
                    end
                    else if (req.request_bytes == 16'd0)
                    begin
                        fin_stat_next = STAT_NO_ROOM;
                        state_next    = S_FIN;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_C_INIT;
                    end
                    else
                    begin
                        state_next = S_A_START;
                    end
                end
            end
            S_A_START:
            begin
                pos_next   = rs;
                end_next   = re;
                rd_addr    = rs[HA_W+1:2];
                state_next = S_A_CHK;
            end
            S_A_CHK:
            begin
                if (h_free && (h_size >= need_reg))
                begin
                    fin_addr_next = heap_base + 32'(pos_reg + HDR_C);
                    fin_stat_next = STAT_DONE;
                    wr_en         = 1'b1;
                    if (rem >= SPLIT_C)
                    begin
                        wr_addr    = split_pos[HA_W+1:2];
                        wr_data    = {1'b1, SZ_W'(rem - HDR_C)};
                        state_next = S_A_WR2;
                    end
                    else
                    begin
                        wr_data    = {1'b0, rd_data[SZ_W-1:0]};
                        state_next = S_FIN;
                    end
                end
                else if (pos_step + HDR_C > end_reg)
                begin
                    if (carved_reg)
                    begin
                        fin_stat_next = STAT_NO_ROOM;
                        state_next    = S_FIN;
                    end
                    else if (r_reg + 1'b1 < count_reg)
                    begin
                        r_next     = r_reg + 1'b1;
                        state_next = S_A_START;
                    end
                    else
                    begin
                        state_next = S_C_INIT;
                    end
                end
                else
                begin
                    pos_next = pos_step;
                    rd_addr  = pos_step[HA_W+1:2];
                end
            end
            S_A_WR2:
            begin
                wr_en      = 1'b1;
                wr_data    = {1'b0, SZ_W'(need_reg)};
                state_next = S_FIN;
            end
            S_C_INIT:
            begin
                if (count_reg >= MAXR_C)
                begin
                    fin_stat_next = STAT_NO_ROOM;
                    state_next    = S_FIN;
                end
                else
                begin
                    bytes_next = PAGE_C;
                    state_next = S_C_SIZE;
                end
            end
            S_C_SIZE:
            begin
                if (bytes_reg < need_reg + HDR_C)
                begin
                    bytes_next = bytes_reg + PAGE_C;
                end
                else if (CW'(carve_reg) + bytes_reg > HEAP_C)
                begin
                    fin_stat_next = STAT_NO_ROOM;
                    state_next    = S_FIN;
                end
                else
                begin
                    wr_en       = 1'b1;
                    wr_addr     = carve_reg[HA_W+1:2];
                    wr_data     = {1'b1, SZ_W'(bytes_reg - HDR_C)};
                    reg_we      = 1'b1;
                    r_next      = count_reg;
                    count_next  = count_reg + 1'b1;
                    carve_next  = carve_reg + OFF_W'(bytes_reg);
                    carved_next = 1'b1;
                    state_next  = S_A_START;
                end
            end
            S_F_FIND:
            begin
                if (r_reg >= count_reg)
                begin
                    fin_stat_next = STAT_FOREIGN;
                    state_next    = S_FIN;
                end
                else if ((off_reg >= rs) && (off_reg < re))
                begin
                    pos_next   = rs;
                    end_next   = re;
                    rd_addr    = rs[HA_W+1:2];
                    state_next = S_F_CHK;
                end
                else
                begin
                    r_next = r_reg + 1'b1;
                end
            end
            S_F_CHK:
            begin
                if (pos_reg + HDR_C == off_reg)
                begin
                    wr_en      = 1'b1;
                    wr_data    = {1'b1, rd_data[SZ_W-1:0]};
                    pos_next   = rs;
                    state_next = S_M_RD;
                end
                else if (pos_step + HDR_C > end_reg)
                begin
                    fin_stat_next = STAT_FOREIGN;
                    state_next    = S_FIN;
                end
                else
                begin
                    pos_next = pos_step;
                    rd_addr  = pos_step[HA_W+1:2];
                end
            end
            S_M_RD:
            begin
                state_next = S_M_CUR;
            end
            S_M_CUR:
            begin
                hc_next  = rd_data;
                nxt_next = pos_step;
                if (pos_step + HDR_C > end_reg)
                begin
                    fin_stat_next = STAT_DONE;
                    state_next    = S_FIN;
                end
                else
                begin
                    rd_addr    = pos_step[HA_W+1:2];
                    state_next = S_M_NXT;
                end
            end
            S_M_NXT:
            begin
                if (hc_reg[SZ_W] && h_free)
                begin
                    wr_en   = 1'b1;
                    wr_data = {1'b1, SZ_W'(merged)};
                end
                else
                begin
                    pos_next = nxt_reg;
                end
                state_next = S_M_RD;
            end
            S_FIN:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            carve_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            carve_reg <= carve_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        need_reg     <= need_next;
        off_reg      <= off_next;
        r_reg        <= r_next;
        pos_reg      <= pos_next;
        end_reg      <= end_next;
        nxt_reg      <= nxt_next;
        bytes_reg    <= bytes_next;
        hc_reg       <= hc_next;
        carved_reg   <= carved_next;
        fin_addr_reg <= fin_addr_next;
        fin_stat_reg <= fin_stat_next;
        if (load_out)
        begin
            out_addr_reg <= fin_addr_reg;
            out_stat_reg <= fin_stat_reg;
        end
        if (reg_we)
        begin
            reg_start[count_reg[RI_W-1:0]] <= carve_reg;
            reg_len[count_reg[RI_W-1:0]]   <= OFF_W'(bytes_reg);
        end
    end
endmodule

`default_nettype wire

// ===== hdl/first_fit_heap_allocator.sv =====
// An allocate walks the block headers of each region one header per cycle
// through the single header ram read port, plus one sizing step per page when
// a region is carved; a free scans the region table one entry per cycle, walks
// the region, and then merges, taking each header through S_M_RD, S_M_CUR and
// S_M_NXT. The result is registered, so a new request is taken while the
// previous result waits. No clearing pass follows reset.
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// first-fit allocator with region carving and free-block merging
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module first_fit_heap_allocator #(
    parameter int PAGE_BYTES  = ffha_pkg::PAGE_BYTES_DEF,
    parameter int HEAP_BYTES  = ffha_pkg::HEAP_BYTES_DEF,
    parameter int MAX_REGIONS = ffha_pkg::MAX_REGIONS_DEF,
    parameter int MIN_PAYLOAD = ffha_pkg::MIN_PAYLOAD_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    ffha_req_if.sink         req,
    ffha_rsp_if.source       rsp,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata
);
    import ffha_pkg::*;

    localparam int SZ_W  = $clog2(HEAP_BYTES);
    localparam int HW    = SZ_W + 1;
    localparam int HA_W  = $clog2(HEAP_BYTES / 4);
    localparam int OFF_W = SZ_W + 1;
    localparam int RC_W  = $clog2(MAX_REGIONS + 1);

    logic [31:0]      heap_base_reg;
    logic [HA_W-1:0]  rd_addr, wr_addr;
    logic [HW-1:0]    rd_data, wr_data;
    logic             wr_en, busy;
    logic [RC_W-1:0]  region_count;
    logic [OFF_W-1:0] carve_offset;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg <= '0;
        end
        else if (cfg_we)
        begin
            heap_base_reg <= cfg_wdata;
        end
    end

    ffha_ctrl #(
        .PAGE_BYTES  (PAGE_BYTES),
        .HEAP_BYTES  (HEAP_BYTES),
        .MAX_REGIONS (MAX_REGIONS),
        .MIN_PAYLOAD (MIN_PAYLOAD)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .rsp          (rsp),
        .heap_base    (heap_base_reg),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .busy         (busy),
        .region_count (region_count),
        .carve_offset (carve_offset)
    );

    ffha_ram #(
        .WIDTH (HW),
        .DEPTH (HEAP_BYTES / 4)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    `FFHA_ASSERT(a_accept_busy, clk, rst_n, (req.valid && req.ready) |=> busy, "request not taken")
    `FFHA_ASSERT_ALWAYS(a_region_cap, clk, region_count <= RC_W'(MAX_REGIONS), "region overflow")
    `FFHA_ASSERT_ALWAYS(a_carve_cap, clk, carve_offset <= OFF_W'(HEAP_BYTES), "carve overflow")
    `FFHA_ASSERT(a_rsp_from_work, clk, rst_n, $rose(rsp.valid) |-> $past(busy), "spurious result")
endmodule

`default_nettype wire
